// ----- sv/ramc_pkg.sv -----
// ----------------------------------------------------------------------------
// ramc_pkg
// Widths, operation codes and word types for the fraction arithmetic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ramc_pkg;

    localparam int OPERAND_WIDTH = 16;

    localparam int NUM_W     = OPERAND_WIDTH;
    localparam int DEN_W     = OPERAND_WIDTH - 1;
    localparam int PROD_W    = 2 * OPERAND_WIDTH;
    localparam int VAL_W     = PROD_W + 1;
    localparam int RES_NUM_W = PROD_W;
    localparam int RES_DEN_W = PROD_W - 2;
    localparam int CNT_W     = $clog2(PROD_W);

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_MUL = 2'd1;
    localparam logic [1:0] FUNC_LT  = 2'd2;
    localparam logic [1:0] FUNC_EQ  = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [NUM_W-1:0] a_num;
        logic [DEN_W-1:0]        a_den;
        logic signed [NUM_W-1:0] b_num;
        logic [DEN_W-1:0]        b_den;
    } req_word_t;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic [RES_DEN_W-1:0]        res_den;
        logic                        flag;
    } rsp_word_t;

endpackage

`default_nettype wire

// ----- sv/rational_add_mul_compare.sv -----
// ----------------------------------------------------------------------------
// rational_add_mul_compare
// Add, multiply or compare two fractions; add/multiply results are reduced
// by the gcd of numerator magnitude and denominator.
//
//   channel | direction | handshake                | word
//   req     | in        | req_valid / req_ready    | func, a_num, a_den, b_num, b_den
//   rsp     | out       | rsp_valid / rsp_ready    | res_num, res_den, flag
//
// One word at a time. Cross products come from three shift-add units, one
// multiplier bit per cycle. Compares skip the gcd loop and the dividers.
// Add/multiply then run a binary gcd loop and two restoring dividers in
// parallel, one quotient bit per cycle. Reset clears control state only.
// A finished word waits in the output register; a stalled rsp holds the
// next result in its final state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rational_add_mul_compare (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire ramc_pkg::req_word_t  req_word,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output ramc_pkg::rsp_word_t       rsp_word
);

    localparam int W  = ramc_pkg::OPERAND_WIDTH;
    localparam int PW = ramc_pkg::PROD_W;
    localparam int VW = ramc_pkg::VAL_W;
    localparam int CW = ramc_pkg::CNT_W;
    localparam int DW = ramc_pkg::RES_DEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_EVEN = 3'd4;
    localparam logic [2:0] S_GCD  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [1:0]           func_reg, func_next;
    logic                 an_neg_reg, an_neg_next;
    logic                 bn_neg_reg, bn_neg_next;
    logic                 fix_reg, fix_next;

    logic [W-1:0]         mc0_reg, mc0_next, mc1_reg, mc1_next, mc2_reg, mc2_next;
    logic [W-1:0]         hi0_reg, hi0_next, hi1_reg, hi1_next, hi2_reg, hi2_next;
    logic [W-1:0]         lo0_reg, lo0_next, lo1_reg, lo1_next, lo2_reg, lo2_next;

    logic signed [VW-1:0] left_reg, left_next, right_reg, right_next;
    logic                 neg_reg, neg_next;
    logic [PW-1:0]        u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [PW-1:0]        qm_reg, qm_next, qd_reg, qd_next;
    logic [PW-1:0]        rm_reg, rm_next, rd_reg, rd_next;

    logic [PW-1:0]        rnum_reg, rnum_next;
    logic [DW-1:0]        rden_reg, rden_next;
    logic                 rflag_reg, rflag_next;

    ramc_pkg::rsp_word_t  rsp_word_reg, rsp_word_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [W:0]           sum0, sum1, sum2;
    logic [W-1:0]         an_mag, bn_mag;
    logic [VW-1:0]        p0_ext, p1_ext, val;
    logic [PW-1:0]        mag, den;
    logic [PW:0]          r2m, r2d;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        an_mag = req_word.a_num[W-1] ? W'(-req_word.a_num) : W'(req_word.a_num);
        bn_mag = req_word.b_num[W-1] ? W'(-req_word.b_num) : W'(req_word.b_num);

        sum0 = {1'b0, hi0_reg} + (lo0_reg[0] ? {1'b0, mc0_reg} : '0);
        sum1 = {1'b0, hi1_reg} + (lo1_reg[0] ? {1'b0, mc1_reg} : '0);
        sum2 = {1'b0, hi2_reg} + (lo2_reg[0] ? {1'b0, mc2_reg} : '0);

        p0_ext = {1'b0, hi0_reg, lo0_reg};
        p1_ext = {1'b0, hi1_reg, lo1_reg};
        val    = (func_reg == ramc_pkg::FUNC_ADD) ? VW'(left_reg + right_reg)
                                                  : VW'(left_reg);
        mag    = val[VW-1] ? PW'(-val) : val[PW-1:0];
        den    = {hi2_reg, lo2_reg};

        r2m = {rm_reg, qm_reg[PW-1]};
        r2d = {rd_reg, qd_reg[PW-1]};

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        an_neg_next    = an_neg_reg;
        bn_neg_next    = bn_neg_reg;
        fix_next       = fix_reg;
        mc0_next       = mc0_reg;
        mc1_next       = mc1_reg;
        mc2_next       = mc2_reg;
        hi0_next       = hi0_reg;
        hi1_next       = hi1_reg;
        hi2_next       = hi2_reg;
        lo0_next       = lo0_reg;
        lo1_next       = lo1_reg;
        lo2_next       = lo2_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        qm_next        = qm_reg;
        qd_next        = qd_reg;
        rm_next        = rm_reg;
        rd_next        = rd_reg;
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        rflag_next     = rflag_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next   = req_word.func;
                    an_neg_next = req_word.a_num[W-1];
                    bn_neg_next = req_word.b_num[W-1];
                    mc0_next    = an_mag;
                    lo0_next    = (req_word.func == ramc_pkg::FUNC_MUL) ? bn_mag
                                                                      : W'(req_word.b_den);
                    mc1_next    = bn_mag;
                    lo1_next    = W'(req_word.a_den);
                    mc2_next    = W'(req_word.a_den);
                    lo2_next    = W'(req_word.b_den);
                    hi0_next    = '0;
                    hi1_next    = '0;
                    hi2_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                hi0_next = sum0[W:1];
                lo0_next = {sum0[0], lo0_reg[W-1:1]};
                hi1_next = sum1[W:1];
                lo1_next = {sum1[0], lo1_reg[W-1:1]};
                hi2_next = sum2[W:1];
                lo2_next = {sum2[0], lo2_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = S_SIGN;
                end
            end

            S_SIGN:
            begin
                if (func_reg == ramc_pkg::FUNC_MUL)
                begin
                    left_next = (an_neg_reg ^ bn_neg_reg) ? -$signed(p0_ext)
                                                          : $signed(p0_ext);
                end
                else
                begin
                    left_next = an_neg_reg ? -$signed(p0_ext) : $signed(p0_ext);
                end
                right_next = bn_neg_reg ? -$signed(p1_ext) : $signed(p1_ext);
                state_next = S_COMB;
            end

            S_COMB:
            begin
                rflag_next = 1'b0;
                rnum_next  = '0;
                rden_next  = DW'(1);
                fix_next   = 1'b0;
                state_next = S_DONE;
                if (func_reg == ramc_pkg::FUNC_LT)
                begin
                    rflag_next = (left_reg < right_reg);
                end
                else if (func_reg == ramc_pkg::FUNC_EQ)
                begin
                    rflag_next = (left_reg == right_reg);
                end
                else if (den == '0)
                begin
                    rden_next = '0;
                end
                else if (mag != '0)
                begin
                    neg_next   = val[VW-1];
                    u_next     = mag;
                    v_next     = den;
                    state_next = S_EVEN;
                end
            end

            // strip common factors of two; the shifted pair become the dividends
            S_EVEN:
            begin
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                end
                else
                begin
                    qm_next    = u_reg;
                    qd_next    = v_reg;
                    state_next = S_GCD;
                end
            end

            S_GCD:
            begin
                if ((u_reg == '0) || (v_reg == '0))
                begin
                    g_next     = u_reg | v_reg;
                    rm_next    = '0;
                    rd_next    = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg >= v_reg)
                begin
                    u_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end

            S_DIV:
            begin
                if (r2m >= {1'b0, g_reg})
                begin
                    rm_next = PW'(r2m - {1'b0, g_reg});
                    qm_next = {qm_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rm_next = r2m[PW-1:0];
                    qm_next = {qm_reg[PW-2:0], 1'b0};
                end
                if (r2d >= {1'b0, g_reg})
                begin
                    rd_next = PW'(r2d - {1'b0, g_reg});
                    qd_next = {qd_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rd_next = r2d[PW-1:0];
                    qd_next = {qd_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1))
                begin
                    fix_next   = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (fix_reg)
                begin
                    rnum_next = neg_reg ? PW'(-qm_reg) : qm_reg;
                    rden_next = qd_reg[DW-1:0];
                    fix_next  = 1'b0;
                end
                else if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_word_next.res_num = rnum_reg;
                    rsp_word_next.res_den = rden_reg;
                    rsp_word_next.flag    = rflag_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            fix_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            fix_reg       <= fix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        func_reg     <= func_next;
        an_neg_reg   <= an_neg_next;
        bn_neg_reg   <= bn_neg_next;
        mc0_reg      <= mc0_next;
        mc1_reg      <= mc1_next;
        mc2_reg      <= mc2_next;
        hi0_reg      <= hi0_next;
        hi1_reg      <= hi1_next;
        hi2_reg      <= hi2_next;
        lo0_reg      <= lo0_next;
        lo1_reg      <= lo1_next;
        lo2_reg      <= lo2_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        neg_reg      <= neg_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        g_reg        <= g_next;
        qm_reg       <= qm_next;
        qd_reg       <= qd_next;
        rm_reg       <= rm_next;
        rd_reg       <= rd_next;
        rnum_reg     <= rnum_next;
        rden_reg     <= rden_next;
        rflag_reg    <= rflag_next;
        rsp_word_reg <= rsp_word_next;
    end

endmodule

`default_nettype wire
